// ===== src/dcss_pkg.sv =====
// ============================================================================
// dcss_pkg
// Shared types, codes and constants of the DMA channel service step block.
// ============================================================================
package dcss_pkg;

    localparam int DEF_NUM_CHANNELS = 4;
    localparam int DEF_ADDRESS_BITS = 24;
    localparam int MAX_PORT_CHANNELS = 4;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [1:0] OP_TICK   = 2'd0;
    localparam logic [1:0] OP_LOAD   = 2'd1;
    localparam logic [1:0] OP_MASK   = 2'd2;
    localparam logic [1:0] OP_STATUS = 2'd3;

    localparam logic [1:0] KIND_VERIFY = 2'd0;
    localparam logic [1:0] KIND_P2M    = 2'd1;
    localparam logic [1:0] KIND_M2P    = 2'd2;
    localparam logic [1:0] KIND_STATUS = 2'd3;

    localparam logic [0:0] CFG_WRAP_IN_64K = 1'b0;
    localparam logic [0:0] CFG_HONOR_HOLD  = 1'b1;

    localparam logic [7:0] MODE_DIR_MASK = 8'h0c;
    localparam logic [7:0] MODE_DIR_P2M  = 8'h04;
    localparam logic [7:0] MODE_DEC      = 8'h20;
    localparam logic [3:0] STATUS_MASK   = 4'h0f;

    typedef struct packed {
        logic [1:0]  op;
        logic [1:0]  sel;
        logic [23:0] address;
        logic [15:0] count;
        logic [7:0]  mode;
        logic [3:0]  mask;
        logic [3:0]  hold;
    } cmd_t;

    function automatic int eff_channels(input int n);
        return (n < MAX_PORT_CHANNELS) ? n : MAX_PORT_CHANNELS;
    endfunction

    function automatic logic [3:0] chan_mask_of(input int n);
        return 4'((1 << eff_channels(n)) - 1);
    endfunction

endpackage

// ===== src/dcss_front.sv =====
// ============================================================================
// dcss_front
// Accepts input transactions, decodes them into commands and queues them.
// ============================================================================
module dcss_front
    import dcss_pkg::*;
#(
    parameter int NUM_CHANNELS = DEF_NUM_CHANNELS
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  action,
    input  logic [1:0]  channel_sel,
    input  logic [23:0] load_address,
    input  logic [15:0] load_count,
    input  logic [7:0]  load_mode,
    input  logic [3:0]  mask_value,
    input  logic [3:0]  hold_mask,
    output logic        q_valid,
    output cmd_t        q_cmd,
    input  logic        q_pop
);

    localparam logic [3:0] CHAN_MASK = chan_mask_of(NUM_CHANNELS);
    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    cmd_t             slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] fill_reg;
    logic [CNT_W-1:0] fill_next;
    logic             push;
    logic             pop;
    cmd_t             cmd_in;

    always_comb
    begin
        cmd_in.op      = action;
        cmd_in.sel     = channel_sel;
        cmd_in.address = load_address;
        cmd_in.count   = load_count;
        cmd_in.mode    = load_mode;
        cmd_in.mask    = mask_value & CHAN_MASK;
        cmd_in.hold    = hold_mask & CHAN_MASK;
    end

    assign in_stall = (fill_reg == CNT_W'(QUEUE_DEPTH));
    assign push     = in_valid && !in_stall;
    assign q_valid  = (fill_reg != '0);
    assign pop      = q_pop && q_valid;
    assign q_cmd    = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? PTR_W'(wr_ptr_reg + 1'b1) : wr_ptr_reg;
        rd_ptr_next = pop ? PTR_W'(rd_ptr_reg + 1'b1) : rd_ptr_reg;
        fill_next   = fill_reg;
        if (push && !pop)
        begin
            fill_next = CNT_W'(fill_reg + 1'b1);
        end
        else if (pop && !push)
        begin
            fill_next = CNT_W'(fill_reg - 1'b1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= cmd_in;
        end
    end

endmodule

// ===== src/dcss_back.sv =====
// ============================================================================
// dcss_back
// Executes queued commands: channel state, per-channel service and results.
// ============================================================================
module dcss_back
    import dcss_pkg::*;
#(
    parameter int NUM_CHANNELS = DEF_NUM_CHANNELS,
    parameter int ADDRESS_BITS = DEF_ADDRESS_BITS
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write,
    input  logic [0:0]  cfg_index,
    input  logic        cfg_data,
    input  logic        q_valid,
    input  cmd_t        q_cmd,
    output logic        q_pop,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  out_channel,
    output logic [1:0]  transfer_kind,
    output logic [23:0] bus_address,
    output logic        terminal_count,
    output logic [3:0]  status_now,
    output logic        last_of_tick
);

    localparam int NCH = eff_channels(NUM_CHANNELS);
    localparam int CIDX_W = (NCH > 1) ? $clog2(NCH) : 1;
    localparam int AW = ADDRESS_BITS;
    localparam logic [3:0] CHAN_MASK = chan_mask_of(NUM_CHANNELS);

    localparam logic ST_IDLE  = 1'b0;
    localparam logic ST_SERVE = 1'b1;

    logic          state_reg;
    logic          state_next;
    logic          wrap_reg;
    logic          honor_reg;
    logic [AW-1:0] addr_reg [NCH];
    logic [AW-1:0] addr_next [NCH];
    logic [15:0]   count_reg [NCH];
    logic [15:0]   count_next [NCH];
    logic [7:0]    mode_reg [NCH];
    logic [7:0]    mode_next [NCH];
    logic [3:0]    active_reg;
    logic [3:0]    active_next;
    logic [3:0]    status_reg;
    logic [3:0]    status_next;
    logic [3:0]    pend_reg;
    logic [3:0]    pend_next;

    logic          out_valid_reg;
    logic          out_valid_next;
    logic [1:0]    out_channel_reg;
    logic [1:0]    out_channel_next;
    logic [1:0]    kind_reg;
    logic [1:0]    kind_next;
    logic [23:0]   bus_address_reg;
    logic [23:0]   bus_address_next;
    logic          tc_reg;
    logic          tc_next;
    logic [3:0]    status_now_reg;
    logic [3:0]    status_now_next;
    logic          last_reg;
    logic          last_next;

    logic          out_free;
    logic [1:0]    pick;
    logic [CIDX_W-1:0] idx;
    logic [CIDX_W-1:0] sel_idx;
    logic [3:0]    pick_bit;
    logic          cur_tc;
    logic [AW-1:0] cur_addr;
    logic [AW-1:0] full_step;
    logic [AW-1:0] wrap_step;
    logic [15:0]   low_step;
    logic [7:0]    cur_mode;
    logic [1:0]    cur_kind;
    logic [AW+23:0] load_wide;
    logic [AW+23:0] out_wide;

    assign out_free = !out_valid_reg || !out_stall;
    assign idx      = pick[CIDX_W-1:0];
    assign sel_idx  = q_cmd.sel[CIDX_W-1:0];
    assign pick_bit = 4'b0001 << pick;
    assign cur_addr = addr_reg[idx];
    assign cur_mode = mode_reg[idx];
    assign cur_tc   = (count_reg[idx] == 16'd0);
    assign load_wide = {{AW{1'b0}}, q_cmd.address};
    assign out_wide  = {24'd0, cur_addr};

    always_comb
    begin
        pick = 2'd0;
        for (int i = NCH - 1; i >= 0; i--)
        begin
            if (pend_reg[i])
            begin
                pick = 2'(i);
            end
        end
    end

    always_comb
    begin
        if ((cur_mode & MODE_DIR_MASK) == 8'h00)
        begin
            cur_kind = KIND_VERIFY;
        end
        else if ((cur_mode & MODE_DIR_MASK) == MODE_DIR_P2M)
        begin
            cur_kind = KIND_P2M;
        end
        else
        begin
            cur_kind = KIND_M2P;
        end
        if ((cur_mode & MODE_DEC) != 8'h00)
        begin
            full_step = AW'(cur_addr - 1'b1);
            low_step  = 16'(cur_addr[15:0] - 1'b1);
        end
        else
        begin
            full_step = AW'(cur_addr + 1'b1);
            low_step  = 16'(cur_addr[15:0] + 1'b1);
        end
        wrap_step       = cur_addr;
        wrap_step[15:0] = low_step;
    end

    always_comb
    begin
        state_next       = state_reg;
        addr_next        = addr_reg;
        count_next       = count_reg;
        mode_next        = mode_reg;
        active_next      = active_reg;
        status_next      = status_reg;
        pend_next        = pend_reg;
        q_pop            = 1'b0;
        out_valid_next   = out_valid_reg && out_stall;
        out_channel_next = out_channel_reg;
        kind_next        = kind_reg;
        bus_address_next = bus_address_reg;
        tc_next          = tc_reg;
        status_now_next  = status_now_reg;
        last_next        = last_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    case (q_cmd.op)
                        OP_LOAD:
                        begin
                            q_pop = 1'b1;
                            if ({1'b0, q_cmd.sel} < 3'(NCH))
                            begin
                                addr_next[sel_idx]  = load_wide[AW-1:0];
                                count_next[sel_idx] = q_cmd.count;
                                mode_next[sel_idx]  = q_cmd.mode;
                            end
                        end
                        OP_MASK:
                        begin
                            q_pop       = 1'b1;
                            active_next = q_cmd.mask & CHAN_MASK;
                        end
                        OP_STATUS:
                        begin
                            if (out_free)
                            begin
                                q_pop            = 1'b1;
                                out_valid_next   = 1'b1;
                                out_channel_next = 2'd0;
                                kind_next        = KIND_STATUS;
                                bus_address_next = 24'd0;
                                tc_next          = 1'b0;
                                status_now_next  = status_reg;
                                last_next        = 1'b1;
                                status_next      = 4'd0;
                            end
                        end
                        OP_TICK:
                        begin
                            q_pop     = 1'b1;
                            pend_next = active_reg & ~(honor_reg ? q_cmd.hold : 4'd0);
                            if (pend_next != 4'd0)
                            begin
                                state_next = ST_SERVE;
                            end
                        end
                        default:
                        begin
                            q_pop = 1'b1;
                        end
                    endcase
                end
            end
            ST_SERVE:
            begin
                if (out_free)
                begin
                    pend_next       = pend_reg & ~pick_bit;
                    count_next[idx] = 16'(count_reg[idx] - 1'b1);
                    addr_next[idx]  = wrap_reg ? wrap_step : full_step;
                    if (cur_tc)
                    begin
                        status_next = (status_reg | pick_bit) & STATUS_MASK;
                        active_next = active_reg & ~pick_bit;
                    end
                    out_valid_next   = 1'b1;
                    out_channel_next = pick;
                    kind_next        = cur_kind;
                    bus_address_next = out_wide[23:0];
                    tc_next          = cur_tc;
                    status_now_next  = status_next;
                    last_next        = (pend_next == 4'd0);
                    if (pend_next == 4'd0)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            wrap_reg      <= 1'b0;
            honor_reg     <= 1'b1;
            active_reg    <= 4'd0;
            status_reg    <= 4'd0;
            pend_reg      <= 4'd0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < NCH; i++)
            begin
                addr_reg[i]  <= '0;
                count_reg[i] <= '0;
                mode_reg[i]  <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            active_reg    <= active_next;
            status_reg    <= status_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
            addr_reg      <= addr_next;
            count_reg     <= count_next;
            mode_reg      <= mode_next;
            if (cfg_write && (cfg_index == CFG_WRAP_IN_64K))
            begin
                wrap_reg <= cfg_data;
            end
            if (cfg_write && (cfg_index == CFG_HONOR_HOLD))
            begin
                honor_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        out_channel_reg <= out_channel_next;
        kind_reg        <= kind_next;
        bus_address_reg <= bus_address_next;
        tc_reg          <= tc_next;
        status_now_reg  <= status_now_next;
        last_reg        <= last_next;
    end

    assign out_valid      = out_valid_reg;
    assign out_channel    = out_channel_reg;
    assign transfer_kind  = kind_reg;
    assign bus_address    = bus_address_reg;
    assign terminal_count = tc_reg;
    assign status_now     = status_now_reg;
    assign last_of_tick   = last_reg;

endmodule

// ===== src/dma_channel_service_step_top.sv =====
// ============================================================================
// dma_channel_service_step_top
// Four-channel DMA address and count sequencer with a command queue.
// ============================================================================
// The input channel (in_valid, in_stall) carries one command per transaction:
// a service tick, a channel load, an active mask write or a status read.
// Commands enter a two-entry queue, so the sender can run ahead of the
// sequencer. The output channel (out_valid, out_stall) carries one transfer
// request or status report per transaction from a single output register.
// A command leaves the queue in the cycle after it is accepted at the
// earliest. Load and mask commands give no result. The result of a status
// read is offered in the cycle after it leaves the queue. A tick is decoded
// first and then serves its channels one at a time, in ascending order,
// through the single channel update datapath; if no channel is served, it
// ends after the decode. Its first result passes the state register and
// then the output register before it is offered.
// Reset clears all channel state, the mask, the status bits and the queue,
// sets the hold option and clears the 64K wrap option. When the receiver
// stalls, the output register holds its transaction, status reads and
// channel service wait, and the queue can fill until in_stall rises.
// Configuration writes must only be made while no command is in flight.
// ============================================================================
module dma_channel_service_step_top
    import dcss_pkg::*;
#(
    parameter int NUM_CHANNELS = DEF_NUM_CHANNELS,
    parameter int ADDRESS_BITS = DEF_ADDRESS_BITS
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write,
    input  logic [0:0]  cfg_index,
    input  logic        cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  action,
    input  logic [1:0]  channel_sel,
    input  logic [23:0] load_address,
    input  logic [15:0] load_count,
    input  logic [7:0]  load_mode,
    input  logic [3:0]  mask_value,
    input  logic [3:0]  hold_mask,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  out_channel,
    output logic [1:0]  transfer_kind,
    output logic [23:0] bus_address,
    output logic        terminal_count,
    output logic [3:0]  status_now,
    output logic        last_of_tick
);

    logic q_valid;
    cmd_t q_cmd;
    logic q_pop;

    dcss_front #(
        .NUM_CHANNELS (NUM_CHANNELS)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .action       (action),
        .channel_sel  (channel_sel),
        .load_address (load_address),
        .load_count   (load_count),
        .load_mode    (load_mode),
        .mask_value   (mask_value),
        .hold_mask    (hold_mask),
        .q_valid      (q_valid),
        .q_cmd        (q_cmd),
        .q_pop        (q_pop)
    );

    dcss_back #(
        .NUM_CHANNELS (NUM_CHANNELS),
        .ADDRESS_BITS (ADDRESS_BITS)
    ) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write      (cfg_write),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .q_valid        (q_valid),
        .q_cmd          (q_cmd),
        .q_pop          (q_pop),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .out_channel    (out_channel),
        .transfer_kind  (transfer_kind),
        .bus_address    (bus_address),
        .terminal_count (terminal_count),
        .status_now     (status_now),
        .last_of_tick   (last_of_tick)
    );

endmodule

// ===== src/dcss_checker.sv =====
// ============================================================================
// dcss_port_checker
// Port-level checks on the output channel of the DMA service step block.
// ============================================================================
module dcss_port_checker
    import dcss_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_stall,
    input logic [1:0]  out_channel,
    input logic [1:0]  transfer_kind,
    input logic [23:0] bus_address,
    input logic        terminal_count,
    input logic [3:0]  status_now,
    input logic        last_of_tick
);

    a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
        else $error("output valid during reset");

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_channel)
            && $stable(transfer_kind) && $stable(bus_address)
            && $stable(terminal_count) && $stable(status_now)
            && $stable(last_of_tick))
        else $error("stalled output transaction changed");

    a_status_shape: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (transfer_kind == KIND_STATUS) |-> last_of_tick
            && (out_channel == 2'd0) && (bus_address == 24'd0) && !terminal_count)
        else $error("status report fields malformed");

    a_tc_status: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && terminal_count |-> ((status_now >> out_channel) & 4'd1) == 4'd1)
        else $error("terminal count without its status bit");

endmodule

bind dma_channel_service_step_top dcss_port_checker u_dcss_port_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_channel    (out_channel),
    .transfer_kind  (transfer_kind),
    .bus_address    (bus_address),
    .terminal_count (terminal_count),
    .status_now     (status_now),
    .last_of_tick   (last_of_tick)
);
